// ----- design/bvas_pkg.sv -----
// ----------------------------------------------------------------------------
// bvas_pkg
// Shared constants, queue entry type and voltage clamp for the battery
// voltage averager and charge estimator.
// ----------------------------------------------------------------------------
package bvas_pkg;

  localparam int unsigned HISTORY_DEPTH = 5;

  localparam int unsigned CODE_W  = 12;
  localparam int unsigned GBYTE_W = 8;
  localparam int unsigned VOLT_W  = 13;
  localparam int unsigned SOC_W   = 7;

  localparam int unsigned SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned SUM_W  = VOLT_W + $clog2(HISTORY_DEPTH);

  // exact floor(sum / HISTORY_DEPTH) by reciprocal multiply
  localparam int unsigned AVG_SH    = SUM_W + $clog2(HISTORY_DEPTH);
  localparam int unsigned RECIP_W   = AVG_SH + 1;
  localparam longint unsigned AVG_RECIP =
    ((64'd1 << AVG_SH) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;

  // floor(x / 100), exact for x below 43690 and for multiples of 4 below 2^17
  localparam int unsigned DIV100_SH    = 19;
  localparam int unsigned DIV100_W     = 13;
  localparam logic [DIV100_W-1:0] DIV100_RECIP = 13'd5243;

  localparam logic [VOLT_W-1:0] V_MAX        = 13'd4200;
  localparam logic [VOLT_W-1:0] V_LOW        = 13'd3500;
  localparam logic [VOLT_W-1:0] V_LOW_SUB    = 13'd3650;
  localparam logic [VOLT_W-1:0] V_FULL       = 13'd4180;
  localparam logic [VOLT_W-1:0] V_KNEE       = 13'd3680;
  localparam logic [VOLT_W-1:0] V_CHG_LO     = 13'd3790;
  localparam logic [VOLT_W-1:0] V_CHG_HI     = 13'd4050;
  localparam logic [VOLT_W-1:0] V_CHG_DROP   = 13'd100;
  localparam logic [VOLT_W-1:0] V_HIST_RESET = 13'd3900;
  localparam logic [VOLT_W-1:0] V_LAST_RESET = 13'd3850;

  localparam logic [SOC_W-1:0] SOC_MAX = 7'd100;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_CNT_W = 2;

  typedef struct packed {
    logic              is_query;
    logic [VOLT_W-1:0] sample_mv;
    logic              gauge_full;
    logic              charging;
  } bvas_item_t;

  function automatic logic [VOLT_W-1:0] clamp_mv(input logic [VOLT_W:0] v);
    logic [VOLT_W-1:0] r;
    if (v >= {1'b0, V_MAX}) begin
      r = V_MAX;
    end else if (v <= {1'b0, V_LOW}) begin
      r = V_LOW_SUB;
    end else begin
      r = v[VOLT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- design/bvas_if.sv -----
// ----------------------------------------------------------------------------
// bvas_if
// Request and response channels of the battery voltage averager.
// ----------------------------------------------------------------------------
interface bvas_in_if;
  import bvas_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [CODE_W-1:0]  cell_code;
  logic [GBYTE_W-1:0] gauge_soc_byte;
  logic               charging;

  modport source (output valid, op, cell_code, gauge_soc_byte, charging, input ready);
  modport sink   (input valid, op, cell_code, gauge_soc_byte, charging, output ready);
endinterface

interface bvas_out_if;
  import bvas_pkg::*;

  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] voltage_mv;
  logic [SOC_W-1:0]  soc_percent;

  modport source (output valid, voltage_mv, soc_percent, input ready);
  modport sink   (input valid, voltage_mv, soc_percent, output ready);
endinterface

// ----- design/bvas_front.sv -----
// ----------------------------------------------------------------------------
// bvas_front
// Request decode: converts a sample code to a clamped mV value and
// classifies the gauge byte before the request enters the queue.
// ----------------------------------------------------------------------------
module bvas_front (
  bvas_in_if.sink                req_i,
  output logic                   push_valid_o,
  output bvas_pkg::bvas_item_t   push_item_o,
  input  logic                   push_ready_i
);
  import bvas_pkg::*;

  localparam logic [6:0] TENS_SAT   = 7'd10;
  localparam logic [4:0] OFFSET_MAX = 5'd20;
  localparam logic [6:0] GAUGE_FULL = 7'd99;

  logic [CODE_W+2:0]            code_x5;
  logic [VOLT_W-1:0]            mv;
  logic [VOLT_W+DIV100_W-1:0]   tens_prod;
  logic [6:0]                   tens;
  logic [4:0]                   offset;
  logic [VOLT_W:0]              v_raw;

  assign code_x5   = ({3'b000, req_i.cell_code} << 2) + {3'b000, req_i.cell_code};
  assign mv        = code_x5[CODE_W+2:2];
  assign tens_prod = {{DIV100_W{1'b0}}, mv} * {{VOLT_W{1'b0}}, DIV100_RECIP};
  assign tens      = tens_prod[DIV100_SH +: 7];
  assign offset    = (tens >= TENS_SAT) ? OFFSET_MAX : {tens[3:0], 1'b0};
  assign v_raw     = {1'b0, mv} + {{(VOLT_W-4){1'b0}}, offset};

  assign push_item_o.is_query   = req_i.op;
  assign push_item_o.sample_mv  = clamp_mv(v_raw);
  assign push_item_o.gauge_full = (req_i.gauge_soc_byte[GBYTE_W-1:1] >= GAUGE_FULL);
  assign push_item_o.charging   = req_i.charging;

  assign push_valid_o = req_i.valid;
  assign req_i.ready  = push_ready_i;

endmodule

// ----- design/bvas_fifo.sv -----
// ----------------------------------------------------------------------------
// bvas_fifo
// Two-entry queue between request decode and the state/estimate pipeline.
// ----------------------------------------------------------------------------
module bvas_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  input  bvas_pkg::bvas_item_t push_item_i,
  output logic                 push_ready_o,
  output logic                 pop_valid_o,
  output bvas_pkg::bvas_item_t pop_item_o,
  input  logic                 pop_ready_i
);
  import bvas_pkg::*;

  bvas_item_t            mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  push, pop;

  assign push_ready_o = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- design/bvas_back.sv -----
// ----------------------------------------------------------------------------
// bvas_back
// Voltage history, running average and stored voltage update, followed by
// the charge percent stage and the response register.
// ----------------------------------------------------------------------------
module bvas_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  input  bvas_pkg::bvas_item_t pop_item_i,
  output logic                 pop_ready_o,
  bvas_out_if.source           rsp_o
);
  import bvas_pkg::*;

  localparam int unsigned DIV10_SH = 16;
  localparam logic [12:0] DIV10_RECIP = 13'd6554;
  localparam logic [11:0] HI_OFS = 12'd572;
  localparam logic [11:0] LO_OFS = 12'd1089;

  // state
  logic [VOLT_W-1:0] hist_q [HISTORY_DEPTH];
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              primed_q;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [VOLT_W-1:0] last_q, last_d;

  // stage 1 and response register
  logic              s1_valid_q;
  logic [VOLT_W-1:0] s1_volt_q;
  logic              s1_query_q;
  logic              s1_full_q;
  logic              out_valid_q;
  logic [VOLT_W-1:0] out_volt_q;
  logic [SOC_W-1:0]  out_soc_q, soc_d;

  logic out_load, s1_load, pop;

  logic [VOLT_W-1:0]          v;
  logic [SUM_W+RECIP_W-1:0]   avg_prod;
  logic [VOLT_W-1:0]          lv_c;
  logic                       full;
  logic                       drop;

  logic [16:0] x16;
  logic [29:0] hi_prod;
  logic [11:0] hi_a;
  logic [14:0] y3;
  logic [27:0] lo_prod;
  logic [11:0] lo_a;
  logic [11:0] pct_raw;

  assign out_load    = !out_valid_q || rsp_o.ready;
  assign s1_load     = !s1_valid_q || out_load;
  assign pop_ready_o = s1_load;
  assign pop         = pop_valid_i && s1_load;

  // sample path: running sum over the history ring
  assign v = pop_item_i.sample_mv;

  always_comb begin
    if (primed_q) begin
      sum_d = sum_q - SUM_W'(hist_q[slot_q]) + SUM_W'(v);
    end else begin
      sum_d = SUM_W'(v) * SUM_W'(HISTORY_DEPTH);
    end
    slot_d = (32'(slot_q) == HISTORY_DEPTH - 1) ? '0 : slot_q + 1'b1;
  end

  assign avg_prod = (SUM_W+RECIP_W)'(sum_d) * (SUM_W+RECIP_W)'(AVG_RECIP);

  // query path
  assign lv_c = clamp_mv({1'b0, last_q});
  assign full = pop_item_i.gauge_full && (lv_c >= V_FULL);
  assign drop = !full && pop_item_i.charging && (lv_c <= V_CHG_HI) && (lv_c >= V_CHG_LO);

  always_comb begin
    if (pop_item_i.is_query) begin
      last_d = drop ? lv_c - V_CHG_DROP : lv_c;
    end else if (primed_q) begin
      last_d = avg_prod[AVG_SH +: VOLT_W];
    end else begin
      last_d = v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= V_HIST_RESET;
      end
      slot_q   <= '0;
      primed_q <= 1'b0;
      sum_q    <= SUM_W'(V_HIST_RESET) * SUM_W'(HISTORY_DEPTH);
      last_q   <= V_LAST_RESET;
    end else if (pop) begin
      last_q <= last_d;
      if (!pop_item_i.is_query) begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
          if (!primed_q || (32'(slot_q) == i)) begin
            hist_q[i] <= v;
          end
        end
        slot_q   <= slot_d;
        primed_q <= 1'b1;
        sum_q    <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_volt_q  <= last_d;
      s1_query_q <= pop_item_i.is_query;
      s1_full_q  <= full;
    end
  end

  // charge percent from the stored voltage
  assign x16     = {s1_volt_q, 4'b0000};
  assign hi_prod = {13'b0, x16} * {17'b0, DIV100_RECIP};
  assign hi_a    = hi_prod[DIV100_SH +: 11] == 11'd0 ? 12'd0 : {1'b0, hi_prod[DIV100_SH +: 11]};
  assign y3      = ({2'b00, s1_volt_q} << 1) + {2'b00, s1_volt_q};
  assign lo_prod = {13'b0, y3} * {15'b0, DIV10_RECIP};
  assign lo_a    = lo_prod[DIV10_SH +: 12];

  always_comb begin
    if (s1_volt_q >= V_KNEE) begin
      pct_raw = (hi_a > HI_OFS) ? hi_a - HI_OFS : '0;
    end else begin
      pct_raw = (lo_a > LO_OFS) ? lo_a - LO_OFS : '0;
    end
    if (!s1_query_q) begin
      soc_d = '0;
    end else if (s1_full_q || (pct_raw > 12'(SOC_MAX))) begin
      soc_d = SOC_MAX;
    end else begin
      soc_d = pct_raw[SOC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      out_volt_q <= s1_volt_q;
      out_soc_q  <= soc_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.voltage_mv  = out_volt_q;
  assign rsp_o.soc_percent = out_soc_q;

  // checks
  a_last_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_q <= V_MAX) && (last_q > V_LOW))
    else $error("stored voltage out of range");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(slot_q) < HISTORY_DEPTH)
    else $error("history slot out of range");

  a_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !pop_item_i.is_query |=> primed_q)
    else $error("sample did not prime history");

  a_soc_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_soc_q <= SOC_MAX))
    else $error("charge percent above 100");

  a_full_soc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && s1_valid_q && s1_query_q && s1_full_q |=> (out_soc_q == SOC_MAX))
    else $error("full gauge did not report 100");

endmodule

// ----- design/battery_voltage_average_soc_estimate_core.sv -----
// ----------------------------------------------------------------------------
// battery_voltage_average_soc_estimate_core
// Battery voltage averager and state-of-charge estimator.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the queue has room and returns one response
// per request, in order. A request is decoded into a two-entry queue; on a pop,
// the history and stored voltage update while stage 1 registers the voltage,
// and the charge percent is computed into the response register. The loop that
// bounds the rate is the stored-voltage update (running sum plus a reciprocal
// multiply for the average), which is combinational into its registers, so
// back-to-back samples and queries run at full rate. Backpressure on the
// response side fills the pipeline and queue before the request side stalls.
module battery_voltage_average_soc_estimate_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  bvas_in_if.sink    req_i,
  bvas_out_if.source rsp_o
);
  import bvas_pkg::*;

  logic       push_valid, push_ready;
  bvas_item_t push_item;
  logic       pop_valid, pop_ready;
  bvas_item_t pop_item;

  bvas_front u_front (
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  bvas_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  bvas_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_ready_o (pop_ready),
    .rsp_o       (rsp_o)
  );

endmodule
